>>> src/oid_pe_pkg.sv
// shared types and constants of the object identifier octet encoder
`default_nettype none

package oid_pe_pkg;

  // content buffer depth in octets (8 to 127, so the length fits one octet)
  localparam int CONTENT_DEPTH = 32;
  localparam int IDX_W         = $clog2(CONTENT_DEPTH);
  localparam int CNT_W         = $clog2(CONTENT_DEPTH + 1);

  localparam int ARC_W      = 32;
  // first*40+second needs 38 bits
  localparam int SUBID_W    = 38;
  localparam int RADIX_BITS = 7;
  localparam int MAX_DIGITS = 6;
  localparam int PAD_W      = RADIX_BITS * MAX_DIGITS;
  localparam int DIG_W      = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CONT_BIT = 8'h80;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_FEW_ARCS = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic               has_subid;
    logic               last;
    logic               few_arcs;
    logic [SUBID_W-1:0] subid;
  } queue_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WRITE,
    BK_CLOSE,
    BK_EMIT
  } back_state_e;

endpackage

`default_nettype wire

>>> src/oid_pe_front.sv
// front end: takes arcs, merges the first two, classifies each request
`default_nettype none

module oid_pe_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [oid_pe_pkg::ARC_W-1:0]  arc_value_i,
  input  wire logic                          last_arc_i,
  output logic                               push_o,
  output oid_pe_pkg::queue_entry_t           entry_o
);

  logic [oid_pe_pkg::SUBID_W-1:0] first_x40_q, first_x40_d;
  logic [1:0]                     arcs_seen_q, arcs_seen_d;
  logic [oid_pe_pkg::SUBID_W-1:0] arc_ext;

  assign arc_ext = {{(oid_pe_pkg::SUBID_W - oid_pe_pkg::ARC_W){1'b0}}, arc_value_i};

  always_comb begin
    first_x40_d = first_x40_q;
    arcs_seen_d = arcs_seen_q;
    if (accept_i) begin
      if (arcs_seen_q == 2'd0) begin
        // 40*a = 32*a + 8*a
        first_x40_d = (arc_ext << 5) + (arc_ext << 3);
        arcs_seen_d = 2'd1;
      end else begin
        arcs_seen_d = 2'd2;
      end
      if (last_arc_i) begin
        first_x40_d = '0;
        arcs_seen_d = 2'd0;
      end
    end
  end

  always_comb begin
    push_o             = accept_i && ((arcs_seen_q != 2'd0) || last_arc_i);
    entry_o.has_subid  = (arcs_seen_q != 2'd0);
    entry_o.last       = last_arc_i;
    entry_o.few_arcs   = (arcs_seen_q == 2'd0);
    entry_o.subid      = (arcs_seen_q == 2'd1) ? first_x40_q + arc_ext : arc_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x40_q <= '0;
      arcs_seen_q <= 2'd0;
    end else begin
      first_x40_q <= first_x40_d;
      arcs_seen_q <= arcs_seen_d;
    end
  end

endmodule

`default_nettype wire

>>> src/oid_pe_queue.sv
// short request queue between front and back end
`default_nettype none

module oid_pe_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire oid_pe_pkg::queue_entry_t   entry_i,
  output logic                            full_o,
  input  wire logic                       pop_i,
  output logic                            valid_o,
  output oid_pe_pkg::queue_entry_t        entry_o
);

  oid_pe_pkg::queue_entry_t          slot_q [oid_pe_pkg::QUEUE_DEPTH];
  logic [oid_pe_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [oid_pe_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = (cnt_q == oid_pe_pkg::QCNT_W'(oid_pe_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == oid_pe_pkg::QPTR_W'(oid_pe_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == oid_pe_pkg::QPTR_W'(oid_pe_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + oid_pe_pkg::QCNT_W'(push_i) - oid_pe_pkg::QCNT_W'(pop_i);
    end
  end

endmodule

`default_nettype wire

>>> src/oid_pe_back.sv
// back end: base-128 coding into the content buffer and octet emission
`default_nettype none

module oid_pe_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire oid_pe_pkg::queue_entry_t entry_i,
  output logic                      pop_o,
  output logic                      strobe_o,
  output logic [7:0]                octet_o,
  output logic                      is_length_o,
  output logic                      last_octet_o,
  output logic [1:0]                error_code_o
);

  oid_pe_pkg::back_state_e            state_q, state_d;
  logic [oid_pe_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                               ovf_q, ovf_d;
  logic                               few_q, few_d;
  logic                               last_q, last_d;
  logic [oid_pe_pkg::SUBID_W-1:0]     val_q, val_d;
  logic [oid_pe_pkg::DIG_W-1:0]       rem_q, rem_d;
  logic [oid_pe_pkg::IDX_W-1:0]       out_idx_q, out_idx_d;
  logic [7:0]                         rd_data_q;

  logic [7:0]                         mem_q [oid_pe_pkg::CONTENT_DEPTH];
  logic                               we;
  logic [7:0]                         wr_data;
  logic [oid_pe_pkg::IDX_W-1:0]       rd_addr;

  logic [oid_pe_pkg::PAD_W-1:0]       in_pad, val_pad;
  logic [oid_pe_pkg::DIG_W-1:0]       n_digits;
  logic [oid_pe_pkg::CNT_W:0]         need;
  logic                               fits;
  logic [oid_pe_pkg::DIG_W-1:0]       dig_sel;
  logic                               emit_last;

  assign in_pad  = {{(oid_pe_pkg::PAD_W - oid_pe_pkg::SUBID_W){1'b0}}, entry_i.subid};
  assign val_pad = {{(oid_pe_pkg::PAD_W - oid_pe_pkg::SUBID_W){1'b0}}, val_q};

  // number of base-128 digits of the incoming subidentifier
  always_comb begin
    n_digits = oid_pe_pkg::DIG_W'(1);
    for (int k = 1; k < oid_pe_pkg::MAX_DIGITS; k++) begin
      if (in_pad[oid_pe_pkg::RADIX_BITS*k +: oid_pe_pkg::RADIX_BITS] != '0) begin
        n_digits = oid_pe_pkg::DIG_W'(k + 1);
      end
    end
  end

  assign need = {1'b0, cnt_q} + {{(oid_pe_pkg::CNT_W + 1 - oid_pe_pkg::DIG_W){1'b0}}, n_digits};
  assign fits = !ovf_q && (need <= (oid_pe_pkg::CNT_W + 1)'(oid_pe_pkg::CONTENT_DEPTH));

  assign dig_sel   = rem_q - 1'b1;
  assign emit_last = ({1'b0, out_idx_q} + 1'b1) == cnt_q;

  // next state and register updates
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    few_d     = few_q;
    last_d    = last_q;
    val_d     = val_q;
    rem_d     = rem_q;
    out_idx_d = out_idx_q;
    case (state_q)
      oid_pe_pkg::BK_IDLE: begin
        if (valid_i) begin
          few_d  = entry_i.few_arcs;
          last_d = entry_i.last;
          if (entry_i.has_subid && fits) begin
            val_d   = entry_i.subid;
            rem_d   = n_digits;
            state_d = oid_pe_pkg::BK_WRITE;
          end else begin
            if (entry_i.has_subid) begin
              ovf_d = 1'b1;
            end
            state_d = entry_i.last ? oid_pe_pkg::BK_CLOSE : oid_pe_pkg::BK_IDLE;
          end
        end
      end
      oid_pe_pkg::BK_WRITE: begin
        cnt_d = cnt_q + 1'b1;
        rem_d = rem_q - 1'b1;
        if (rem_q == oid_pe_pkg::DIG_W'(1)) begin
          state_d = last_q ? oid_pe_pkg::BK_CLOSE : oid_pe_pkg::BK_IDLE;
        end
      end
      oid_pe_pkg::BK_CLOSE: begin
        out_idx_d = '0;
        if (few_q || ovf_q || (cnt_q == '0)) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = oid_pe_pkg::BK_IDLE;
        end else begin
          state_d = oid_pe_pkg::BK_EMIT;
        end
      end
      oid_pe_pkg::BK_EMIT: begin
        out_idx_d = out_idx_q + 1'b1;
        if (emit_last) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = oid_pe_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = oid_pe_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs, buffer port control
  always_comb begin
    pop_o        = 1'b0;
    strobe_o     = 1'b0;
    octet_o      = '0;
    is_length_o  = 1'b0;
    last_octet_o = 1'b0;
    error_code_o = oid_pe_pkg::ERR_NONE;
    we           = 1'b0;
    wr_data      = {(rem_q != oid_pe_pkg::DIG_W'(1)),
                    val_pad[oid_pe_pkg::RADIX_BITS*dig_sel +: oid_pe_pkg::RADIX_BITS]};
    rd_addr      = '0;
    case (state_q)
      oid_pe_pkg::BK_IDLE: begin
        pop_o = valid_i;
      end
      oid_pe_pkg::BK_WRITE: begin
        we = 1'b1;
      end
      oid_pe_pkg::BK_CLOSE: begin
        strobe_o = 1'b1;
        if (few_q) begin
          last_octet_o = 1'b1;
          error_code_o = oid_pe_pkg::ERR_FEW_ARCS;
        end else if (ovf_q) begin
          last_octet_o = 1'b1;
          error_code_o = oid_pe_pkg::ERR_OVERFLOW;
        end else begin
          octet_o      = 8'(cnt_q) & ~oid_pe_pkg::CONT_BIT;
          is_length_o  = 1'b1;
          last_octet_o = (cnt_q == '0);
        end
      end
      oid_pe_pkg::BK_EMIT: begin
        strobe_o     = 1'b1;
        octet_o      = rd_data_q;
        last_octet_o = emit_last;
        rd_addr      = out_idx_q + 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[cnt_q[oid_pe_pkg::IDX_W-1:0]] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= oid_pe_pkg::BK_IDLE;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      few_q     <= 1'b0;
      last_q    <= 1'b0;
      rem_q     <= '0;
      out_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      few_q     <= few_d;
      last_q    <= last_d;
      rem_q     <= rem_d;
      out_idx_q <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

`ifndef SYNTHESIS
  a_err_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (error_code_o != oid_pe_pkg::ERR_NONE)) |-> last_octet_o)
    else $error("error result not marked final");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oid_pe_pkg::BK_WRITE) |->
      (cnt_q < oid_pe_pkg::CNT_W'(oid_pe_pkg::CONTENT_DEPTH)) && !ovf_q)
    else $error("content write beyond buffer");

  a_emit_follows_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oid_pe_pkg::BK_CLOSE) && !few_q && !ovf_q && (cnt_q != '0) |=>
      (state_q == oid_pe_pkg::BK_EMIT) && (out_idx_q == '0))
    else $error("content does not follow length octet");

  a_cleared_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_octet_o) |=> (cnt_q == '0) && !ovf_q)
    else $error("identifier state not cleared after final result");
`endif

endmodule

`default_nettype wire

>>> src/oid_per_octet_encoder_core.sv
// top level of the object identifier octet encoder
//
// usage:
//   request channel: drive arc_value_i and last_arc_i with start_i high; the
//   request is taken at a rising edge where busy_o is low. one request per arc,
//   last_arc_i high on the final arc of an identifier.
//   result channel: strobe_o marks one result per cycle on octet_o,
//   is_length_o, last_octet_o and error_code_o. the receiver cannot stall, so
//   results leave at one per cycle once emission starts.
// timing:
//   the front end passes each request into a two-entry queue; the back end
//   pops a request in its idle state, then writes its base-128 digits (1 to
//   6) into the content buffer, which has one write and one read port.
//   with an empty queue the length octet (or the single error result) comes
//   after the last arc's digits are written; the content octets stream one
//   per cycle right after the length octet.
//   busy_o is high only while the request queue is full.
// reset:
//   asynchronous, active low; clears queue, arc tracking and buffer count.
//   buffer contents are not cleared, only entries below the count are output.
`default_nettype none

module oid_per_octet_encoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] arc_value_i,
  input  wire logic        last_arc_i,
  output logic             strobe_o,
  output logic [7:0]       octet_o,
  output logic             is_length_o,
  output logic             last_octet_o,
  output logic [1:0]       error_code_o
);

  logic                     accept;
  logic                     push;
  oid_pe_pkg::queue_entry_t front_entry;
  logic                     q_full;
  logic                     q_valid;
  logic                     pop;
  oid_pe_pkg::queue_entry_t back_entry;

  // request taken when not back-pressured by a full queue
  assign busy_o = q_full;
  assign accept = start_i && !q_full;

  // arc merging and classification
  oid_pe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .arc_value_i (arc_value_i),
    .last_arc_i  (last_arc_i),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  // decouples front from back end
  oid_pe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (back_entry)
  );

  // digit coding, buffering and octet output
  oid_pe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .entry_i      (back_entry),
    .pop_o        (pop),
    .strobe_o     (strobe_o),
    .octet_o      (octet_o),
    .is_length_o  (is_length_o),
    .last_octet_o (last_octet_o),
    .error_code_o (error_code_o)
  );

endmodule

`default_nettype wire
